FILE: design/cobp_pkg.sv
// shared types, widths and helpers for the circle vs oriented box push block
// no dependencies; imported by every module of the block
package cobp_pkg;

  // field widths
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned RADIUS_W   = 23;
  localparam int unsigned EXT_W      = 23;
  localparam int unsigned TRIG_W     = 16;
  localparam int unsigned MARGIN_W   = 16;

  // fixed point formats
  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned TRIG_FRAC_BITS  = 14;
  localparam int unsigned MARGIN_FRAC     = 8;
  localparam int unsigned MARGIN_LSH =
    (COORD_FRAC_BITS >= MARGIN_FRAC) ? COORD_FRAC_BITS - MARGIN_FRAC : 0;
  localparam int unsigned MARGIN_RSH =
    (COORD_FRAC_BITS < MARGIN_FRAC) ? MARGIN_FRAC - COORD_FRAC_BITS : 0;

  // datapath widths
  localparam int unsigned DIFF_W  = COORD_W + 1;                  // point - centre
  localparam int unsigned PROD_W  = DIFF_W + TRIG_W;              // forward product
  localparam int unsigned LOCAL_W = PROD_W + 1 - TRIG_FRAC_BITS;  // local coordinate
  localparam int unsigned LIM_W   = RADIUS_W + 2;                 // 2r + extent
  localparam int unsigned CMP_W   = LOCAL_W + 2;                  // 2u vs limit
  localparam int unsigned MAG_W   = RADIUS_W + 2 + MARGIN_LSH;    // push magnitude
  localparam int unsigned BPROD_W = LOCAL_W + TRIG_W;             // backward product
  localparam int unsigned BSUM_W  = BPROD_W + 1;
  localparam int unsigned ROT_W   = BSUM_W - TRIG_FRAC_BITS;
  localparam int unsigned POS_W   = ROT_W + 1;                    // rotated + centre

  // default queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_COS_ANGLE   = 3'd2,
    CFG_SIN_ANGLE   = 3'd3,
    CFG_BOX_WIDTH   = 3'd4,
    CFG_BOX_HEIGHT  = 3'd5,
    CFG_PUSH_MARGIN = 3'd6
  } cfg_idx_e;

  // reset values of the registers
  localparam logic signed [COORD_W-1:0] RST_CENTER_X    = '0;
  localparam logic signed [COORD_W-1:0] RST_CENTER_Y    = '0;
  localparam logic signed [TRIG_W-1:0]  RST_COS_ANGLE   = 16'sd16384;
  localparam logic signed [TRIG_W-1:0]  RST_SIN_ANGLE   = '0;
  localparam logic [EXT_W-1:0]          RST_BOX_WIDTH   = '0;
  localparam logic [EXT_W-1:0]          RST_BOX_HEIGHT  = '0;
  localparam logic [MARGIN_W-1:0]       RST_PUSH_MARGIN = 16'd768;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [TRIG_W-1:0]  cos_angle;
    logic signed [TRIG_W-1:0]  sin_angle;
    logic [EXT_W-1:0]          box_width;
    logic [EXT_W-1:0]          box_height;
    logic [MARGIN_W-1:0]       push_margin;
  } cobp_cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [LOCAL_W-1:0] ux;
    logic signed [LOCAL_W-1:0] uy;
  } cobp_item_t;

  // clamp to the coordinate range
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [POS_W-1:0] v
  );
    logic [POS_W-COORD_W:0] upper;
    upper = v[POS_W-1:COORD_W-1];
    if ((&upper) || !(|upper)) begin
      return v[COORD_W-1:0];
    end else if (v[POS_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: design/cobp_front.sv
// front pipeline: offset, rotation into box frame, hit test and push
// depends on cobp_pkg
module cobp_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic signed [cobp_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [cobp_pkg::COORD_W-1:0] point_y_i,
  input  logic [cobp_pkg::RADIUS_W-1:0]      point_radius_i,
  input  cobp_pkg::cobp_cfg_t                cfg_i,
  output logic                               push_o,
  output cobp_pkg::cobp_item_t               item_o
);
  import cobp_pkg::*;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: offset from centre
  logic signed [DIFF_W-1:0]  dx1_q, dy1_q;
  logic signed [COORD_W-1:0] px1_q, py1_q;
  logic [RADIUS_W-1:0]       r1_q;

  // stage 2: products
  logic signed [PROD_W-1:0]  dxc2_q, dys2_q, dyc2_q, dxs2_q;
  logic signed [COORD_W-1:0] px2_q, py2_q;
  logic [RADIUS_W-1:0]       r2_q;

  // stage 3: local coordinates
  logic signed [LOCAL_W-1:0] ux3_q, uy3_q;
  logic signed [COORD_W-1:0] px3_q, py3_q;
  logic [RADIUS_W-1:0]       r3_q;

  // stage 4: classified item
  cobp_item_t item_q;

  logic signed [PROD_W:0]    sum_x, sum_y;
  logic [LIM_W-1:0]          lim_x, lim_y;
  logic signed [CMP_W-1:0]   u2_x, u2_y, slim_x, slim_y;
  logic                      in_x, in_y, hit;
  logic [MAG_W-1:0]          margin_al, mag_x, mag_y;
  logic signed [LOCAL_W-1:0] mag_xs, mag_ys, ux_new, uy_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_comb begin
    sum_x = (PROD_W+1)'(dxc2_q) + (PROD_W+1)'(dys2_q);
    sum_y = (PROD_W+1)'(dyc2_q) - (PROD_W+1)'(dxs2_q);
  end

  // hit test on doubled values so odd extents are exact
  always_comb begin
    lim_x  = (LIM_W'(r3_q) << 1) + LIM_W'(cfg_i.box_width);
    lim_y  = (LIM_W'(r3_q) << 1) + LIM_W'(cfg_i.box_height);
    slim_x = CMP_W'(lim_x);
    slim_y = CMP_W'(lim_y);
    u2_x   = CMP_W'(ux3_q) <<< 1;
    u2_y   = CMP_W'(uy3_q) <<< 1;
    in_x   = (u2_x < slim_x) && (u2_x > -slim_x);
    in_y   = (u2_y < slim_y) && (u2_y > -slim_y);
    hit    = in_x && in_y;

    margin_al = (MAG_W'(cfg_i.push_margin) << MARGIN_LSH) >> MARGIN_RSH;
    mag_x     = MAG_W'(r3_q) + MAG_W'(cfg_i.box_width >> 1) + margin_al;
    mag_y     = MAG_W'(r3_q) + MAG_W'(cfg_i.box_height >> 1) + margin_al;
    mag_xs    = LOCAL_W'(mag_x);
    mag_ys    = LOCAL_W'(mag_y);

    // shorter axis gets pushed, y when width is not below height
    ux_new = ux3_q;
    uy_new = uy3_q;
    if (cfg_i.box_width < cfg_i.box_height) begin
      ux_new = (ux3_q > 0) ? mag_xs : -mag_xs;
    end else begin
      uy_new = (uy3_q > 0) ? mag_ys : -mag_ys;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= DIFF_W'(point_x_i) - DIFF_W'(cfg_i.center_x);
    dy1_q <= DIFF_W'(point_y_i) - DIFF_W'(cfg_i.center_y);
    px1_q <= point_x_i;
    py1_q <= point_y_i;
    r1_q  <= point_radius_i;

    dxc2_q <= PROD_W'(dx1_q) * PROD_W'(cfg_i.cos_angle);
    dys2_q <= PROD_W'(dy1_q) * PROD_W'(cfg_i.sin_angle);
    dyc2_q <= PROD_W'(dy1_q) * PROD_W'(cfg_i.cos_angle);
    dxs2_q <= PROD_W'(dx1_q) * PROD_W'(cfg_i.sin_angle);
    px2_q  <= px1_q;
    py2_q  <= py1_q;
    r2_q   <= r1_q;

    ux3_q <= LOCAL_W'(sum_x >>> TRIG_FRAC_BITS);
    uy3_q <= LOCAL_W'(sum_y >>> TRIG_FRAC_BITS);
    px3_q <= px2_q;
    py3_q <= py2_q;
    r3_q  <= r2_q;

    item_q.hit     <= hit;
    item_q.point_x <= px3_q;
    item_q.point_y <= py3_q;
    item_q.ux      <= ux_new;
    item_q.uy      <= uy_new;
  end

  assign push_o = v4_q;
  assign item_o = item_q;

endmodule

FILE: design/cobp_queue.sv
// small first-in first-out queue of classified items between front and back
// depends on cobp_pkg
module cobp_queue #(
  parameter int unsigned DEPTH = cobp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cobp_pkg::cobp_item_t push_item_i,
  input  logic                 pop_i,
  output cobp_pkg::cobp_item_t head_o,
  output logic                 empty_o,
  output logic                 full_o
);
  import cobp_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cobp_item_t    mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: design/cobp_back.sv
// back pipeline: rotate pushed point back, add centre, saturate, output register
// depends on cobp_pkg
module cobp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                empty_i,
  input  cobp_pkg::cobp_item_t                item_i,
  input  cobp_pkg::cobp_cfg_t                 cfg_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic signed [cobp_pkg::COORD_W-1:0] out_x_o,
  output logic signed [cobp_pkg::COORD_W-1:0] out_y_o
);
  import cobp_pkg::*;

  logic en;
  logic v1_q, v2_q, ov_q;

  // stage 1: products
  logic signed [BPROD_W-1:0] uxc1_q, uys1_q, uxs1_q, uyc1_q;
  logic                      hit1_q;
  logic signed [COORD_W-1:0] px1_q, py1_q;

  // stage 2: rotated back plus centre
  logic signed [POS_W-1:0]   x2_q, y2_q;
  logic                      hit2_q;
  logic signed [COORD_W-1:0] px2_q, py2_q;

  // output register
  logic                      hit_q;
  logic signed [COORD_W-1:0] ox_q, oy_q;

  logic signed [BSUM_W-1:0]  sum_x, sum_y;
  logic signed [ROT_W-1:0]   rot_x, rot_y;

  // whole back end advances when the output register is free or taken
  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_comb begin
    sum_x = BSUM_W'(uxc1_q) - BSUM_W'(uys1_q);
    sum_y = BSUM_W'(uxs1_q) + BSUM_W'(uyc1_q);
    rot_x = ROT_W'(sum_x >>> TRIG_FRAC_BITS);
    rot_y = ROT_W'(sum_y >>> TRIG_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= !empty_i;
      v2_q <= v1_q;
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      uxc1_q <= BPROD_W'(item_i.ux) * BPROD_W'(cfg_i.cos_angle);
      uys1_q <= BPROD_W'(item_i.uy) * BPROD_W'(cfg_i.sin_angle);
      uxs1_q <= BPROD_W'(item_i.ux) * BPROD_W'(cfg_i.sin_angle);
      uyc1_q <= BPROD_W'(item_i.uy) * BPROD_W'(cfg_i.cos_angle);
      hit1_q <= item_i.hit;
      px1_q  <= item_i.point_x;
      py1_q  <= item_i.point_y;

      x2_q   <= POS_W'(rot_x) + POS_W'(cfg_i.center_x);
      y2_q   <= POS_W'(rot_y) + POS_W'(cfg_i.center_y);
      hit2_q <= hit1_q;
      px2_q  <= px1_q;
      py2_q  <= py1_q;

      hit_q  <= hit2_q;
      ox_q   <= hit2_q ? sat_coord(x2_q) : px2_q;
      oy_q   <= hit2_q ? sat_coord(y2_q) : py2_q;
    end
  end

  assign out_valid_o = ov_q;
  assign hit_o       = hit_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;

endmodule

FILE: design/circle_obb_collide_push.sv
// top level of the circle vs oriented box collision and push-out block
// depends on cobp_pkg, cobp_front, cobp_queue, cobp_back
//
// usage:
//   s_axis carries one query item per handshake: a point and a radius. m_axis
//   returns one result item per query, in order: the resolved point in tdata
//   and the hit flag in tuser. the box (centre, cos/sin, width, height, push
//   margin) sits in registers written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i; write them only while no query is in flight.
// path: an accepted item passes the front stages, the queue and the back
//   stages in that order before its result shows on m_axis.
// throughput: one item per cycle while s_axis_tready is high; the forward path
//   is a 4 stage pipeline (offset, products, local sums, hit test and push) and
//   the return path a 3 stage pipeline (products, sums plus centre, saturate),
//   each with its multipliers in the products stage.
// stalls: the front pipeline never stops; a credit counter admits an item
//   only while a queue slot is reserved for it, so s_axis_tready drops once
//   QUEUE_DEPTH items are in front or queue. the back end freezes while the
//   output register holds an untaken result.
// reset: clears all valids, the queue and the credit count, and loads the
//   register defaults (identity rotation, zero box, margin 3.0).
module circle_obb_collide_push #(
  parameter int unsigned QUEUE_DEPTH = cobp_pkg::QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // query stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [71:0]                       s_axis_tdata,  // point_x, point_y, point_radius, pad
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,  // out_x, out_y
  output logic [0:0]                        m_axis_tuser,  // hit
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [cobp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cobp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import cobp_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cobp_cfg_t  cfg_q;
  cobp_item_t f_item, q_head;
  logic       f_push, q_pop, q_empty, q_full;
  logic       s_fire;
  logic [CW-1:0] credit_q, credit_d;

  logic signed [COORD_W-1:0] in_x, in_y, res_x, res_y;
  logic [RADIUS_W-1:0]       in_r;
  logic                      res_hit;

  // unpack query fields, lowest first
  assign in_x = s_axis_tdata[COORD_W-1:0];
  assign in_y = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_r = s_axis_tdata[2*COORD_W+RADIUS_W-1:2*COORD_W];

  // register file, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x    <= RST_CENTER_X;
      cfg_q.center_y    <= RST_CENTER_Y;
      cfg_q.cos_angle   <= RST_COS_ANGLE;
      cfg_q.sin_angle   <= RST_SIN_ANGLE;
      cfg_q.box_width   <= RST_BOX_WIDTH;
      cfg_q.box_height  <= RST_BOX_HEIGHT;
      cfg_q.push_margin <= RST_PUSH_MARGIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:    cfg_q.center_x    <= cfg_wdata_i[COORD_W-1:0];
        CFG_CENTER_Y:    cfg_q.center_y    <= cfg_wdata_i[COORD_W-1:0];
        CFG_COS_ANGLE:   cfg_q.cos_angle   <= cfg_wdata_i[TRIG_W-1:0];
        CFG_SIN_ANGLE:   cfg_q.sin_angle   <= cfg_wdata_i[TRIG_W-1:0];
        CFG_BOX_WIDTH:   cfg_q.box_width   <= cfg_wdata_i[EXT_W-1:0];
        CFG_BOX_HEIGHT:  cfg_q.box_height  <= cfg_wdata_i[EXT_W-1:0];
        CFG_PUSH_MARGIN: cfg_q.push_margin <= cfg_wdata_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // credits: one per item between accept and queue pop
  assign s_axis_tready = (credit_q < CW'(QUEUE_DEPTH));
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    credit_d = credit_q;
    if (s_fire && !q_pop) begin
      credit_d = credit_q + 1'b1;
    end else if (q_pop && !s_fire) begin
      credit_d = credit_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_d;
    end
  end

  cobp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_fire),
    .point_x_i      (in_x),
    .point_y_i      (in_y),
    .point_radius_i (in_r),
    .cfg_i          (cfg_q),
    .push_o         (f_push),
    .item_o         (f_item)
  );

  cobp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_push),
    .push_item_i (f_item),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  cobp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .item_i      (q_head),
    .cfg_i       (cfg_q),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .hit_o       (res_hit),
    .out_x_o     (res_x),
    .out_y_o     (res_y)
  );

  assign m_axis_tdata = {res_y, res_x};
  assign m_axis_tuser = res_hit;

  // credit count never passes the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_q <= CW'(QUEUE_DEPTH))
    else $error("credit count above queue depth");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(f_push && q_full))
    else $error("front pushed into full queue");

  // no credits out means nothing can be waiting in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (credit_q == '0) |-> q_empty)
    else $error("queue holds items with no credit taken");

  // an accepted item always takes a credit on the next edge unless one returns
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !q_pop) |=> (credit_q == $past(credit_q) + 1'b1))
    else $error("credit not taken for accepted item");

endmodule

FILE: tb/circle_obb_collide_push_tb.sv
// self-checking testbench for circle_obb_collide_push: point queries against one
// oriented box, checked item by item against a predictor built into this file
// depends on cobp_pkg and the circle_obb_collide_push rtl
module circle_obb_collide_push_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cobp_pkg::*;

  // index that maps to no register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
  localparam longint COORD_TOP    = 8388607;
  localparam longint COORD_BOTTOM = -8388608;

  // unit rotations, q1.14
  localparam int UNIT_COS [8] = '{16384, 11585, 0, -11585, -16384, 15137, -6270, 6270};
  localparam int UNIT_SIN [8] = '{0, 11585, 16384, 11585, 0, 6270, 15137, -15137};

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [RADIUS_W-1:0]       r;
  } query_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } push_res_t;

  // directed row: query plus, where typed, the result it must give
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [RADIUS_W-1:0]       r;
    logic                      typed;
    logic                      hit;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } dir_row_t;

  // all rows run on the reset box: identity rotation, zero size, margin 3.0
  // so a hit means |p| < r on both axes and the push goes along y
  localparam int N_DIR = 17;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{0, 0, 0, 1'b1, 1'b0, 0, 0},                      // zero radius never hits
    '{0, 0, 256, 1'b1, 1'b1, 0, -1024},                // zero local y pushes negative
    '{0, 100, 256, 1'b1, 1'b1, 0, 1024},               // positive local y
    '{0, -100, 256, 1'b1, 1'b1, 0, -1024},             // negative local y
    '{255, 0, 256, 1'b1, 1'b1, 255, -1024},            // just inside on x
    '{256, 0, 256, 1'b1, 1'b0, 256, 0},                // on the boundary is a miss
    '{8388607, -8388608, 8388607, 1'b1, 1'b0, 8388607, -8388608},
    '{-8388608, 8388607, 8388607, 1'b1, 1'b0, -8388608, 8388607},
    '{0, 8388606, 8388607, 1'b1, 1'b1, 0, 8388607},    // push saturates high
    '{0, -8388606, 8388607, 1'b1, 1'b1, 0, -8388608},  // push saturates low
    '{100, -50, 8388607, 1'b1, 1'b1, 100, -8388608},
    '{-8388608, -8388608, 0, 1'b1, 1'b0, -8388608, -8388608},
    '{8388607, 8388607, 0, 1'b1, 1'b0, 8388607, 8388607},
    '{1, 1, 2, 1'b0, 1'b0, 0, 0},
    '{-1, -1, 2, 1'b0, 1'b0, 0, 0},
    '{12345, -6789, 20000, 1'b0, 1'b0, 0, 0},
    '{-4000000, 3000000, 5592405, 1'b0, 1'b0, 0, 0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [71:0]           s_axis_tdata;   // point_x, point_y, point_radius, pad
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;   // out_x, out_y
  logic [0:0]            m_axis_tuser;   // hit
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  circle_obb_collide_push dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // testbench copy of the box registers, kept in step with every write
  cobp_cfg_t box_cfg;
  // resolved points still owed by the block, oldest first
  push_res_t pending_pushes [$];
  int        mismatch_count;
  int        burst_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_TOP) return COORD_TOP[COORD_W-1:0];
    if (v < COORD_BOTTOM) return COORD_BOTTOM[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  // strict overlap on one local axis, compared at twice the scale so odd
  // extents are judged exactly
  function automatic bit axis_overlaps(input longint u, input longint rad, input longint ext);
    longint lim2;
    lim2 = 2 * rad + ext;
    return (2 * u < lim2) && (2 * u > -lim2);
  endfunction

  // rotate into the box frame, test, push along the shorter axis, rotate back
  function automatic push_res_t predict_push(input query_t q);
    longint px, py, rad, cx, cy, ca, sa, w, h, mg, dx, dy, ux, uy;
    push_res_t res;
    px  = q.px;
    py  = q.py;
    rad = q.r;
    cx  = box_cfg.center_x;
    cy  = box_cfg.center_y;
    ca  = box_cfg.cos_angle;
    sa  = box_cfg.sin_angle;
    w   = box_cfg.box_width;
    h   = box_cfg.box_height;
    mg  = box_cfg.push_margin;  // already at 8 fraction bits
    dx  = px - cx;
    dy  = py - cy;
    // >>> on a signed longint is floor division by the power of two
    ux  = (dx * ca + dy * sa) >>> TRIG_FRAC_BITS;
    uy  = (dy * ca - dx * sa) >>> TRIG_FRAC_BITS;
    res.hit = axis_overlaps(ux, rad, w) && axis_overlaps(uy, rad, h);
    res.x = q.px;
    res.y = q.py;
    if (res.hit) begin
      // zero goes to the negative side
      if (w < h) begin
        ux = (ux > 0) ? rad + (w >>> 1) + mg : -(rad + (w >>> 1) + mg);
      end else begin
        uy = (uy > 0) ? rad + (h >>> 1) + mg : -(rad + (h >>> 1) + mg);
      end
      res.x = clamp_coord(((ux * ca - uy * sa) >>> TRIG_FRAC_BITS) + cx);
      res.y = clamp_coord(((ux * sa + uy * ca) >>> TRIG_FRAC_BITS) + cy);
    end
    return res;
  endfunction

  // one register write; the testbench copy keeps only the register's width
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      CFG_CENTER_X:    box_cfg.center_x    = data[COORD_W-1:0];
      CFG_CENTER_Y:    box_cfg.center_y    = data[COORD_W-1:0];
      CFG_COS_ANGLE:   box_cfg.cos_angle   = data[TRIG_W-1:0];
      CFG_SIN_ANGLE:   box_cfg.sin_angle   = data[TRIG_W-1:0];
      CFG_BOX_WIDTH:   box_cfg.box_width   = data[EXT_W-1:0];
      CFG_BOX_HEIGHT:  box_cfg.box_height  = data[EXT_W-1:0];
      CFG_PUSH_MARGIN: box_cfg.push_margin = data[MARGIN_W-1:0];
      default: ;  // unmapped index, dropped
    endcase
  endtask

  // box setting per phase: fixed corners first, random boxes after that
  task automatic load_box(input int phase);
    logic [CFG_DATA_W-1:0] cen_x, cen_y, cos_v, sin_v, wid, hgt, mrg;
    int pick;
    case (phase)
      0: begin
        cen_x = 0; cen_y = 0; cos_v = 16384; sin_v = 0;
        wid = 4096; hgt = 2048; mrg = 768;
      end
      1: begin
        // quarter turn, tall box so the push goes along x
        cen_x = COORD_TOP[CFG_DATA_W-1:0]; cen_y = COORD_TOP[CFG_DATA_W-1:0];
        cos_v = 0; sin_v = 16384;
        wid = 1000; hgt = 5000; mrg = 0;
      end
      2: begin
        cen_x = COORD_BOTTOM[CFG_DATA_W-1:0]; cen_y = COORD_BOTTOM[CFG_DATA_W-1:0];
        cos_v = -16384; sin_v = 0;
        wid = 8388607; hgt = 8388607; mrg = 65535;
      end
      3: begin
        cen_x = CFG_DATA_W'($urandom_range(0, 4000) - 2000);
        cen_y = CFG_DATA_W'($urandom_range(0, 4000) - 2000);
        cos_v = 11585; sin_v = 11585; wid = 3000; hgt = 3001; mrg = 65535;
      end
      4: begin
        // trig values past +/-1.0 are taken as they are
        cen_x = 0; cen_y = 0; cos_v = 24'h008000; sin_v = 24'h007fff;
        wid = 0; hgt = 0; mrg = 1;
      end
      5: begin
        cen_x = 500; cen_y = -500; cos_v = 24'hff7fff; sin_v = 24'h808000;
        wid = 9000; hgt = 9000; mrg = 256;
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          cen_x = CFG_DATA_W'($urandom); cen_y = CFG_DATA_W'($urandom);
        end else begin
          cen_x = CFG_DATA_W'($urandom_range(0, 40000) - 20000);
          cen_y = CFG_DATA_W'($urandom_range(0, 40000) - 20000);
        end
        pick = $urandom_range(0, 8);
        if (pick == 8) begin
          cos_v = CFG_DATA_W'($urandom); sin_v = CFG_DATA_W'($urandom);
        end else begin
          // junk above bit 15 must not reach the register
          cos_v = {8'($urandom_range(0, 255)), UNIT_COS[pick][15:0]};
          sin_v = {8'($urandom_range(0, 255)), UNIT_SIN[pick][15:0]};
        end
        wid = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                        : $urandom_range(0, 20000));
        hgt = CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom
                                                        : $urandom_range(0, 20000));
        mrg = CFG_DATA_W'($urandom);
      end
    endcase
    write_reg(CFG_CENTER_X, cen_x);
    write_reg(CFG_CENTER_Y, cen_y);
    write_reg(CFG_COS_ANGLE, cos_v);
    write_reg(CFG_SIN_ANGLE, sin_v);
    write_reg(CFG_BOX_WIDTH, wid);
    write_reg(CFG_BOX_HEIGHT, hgt);
    write_reg(CFG_PUSH_MARGIN, mrg);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offer one item in bursts with random gaps; the result it must give is
  // queued once the block takes it
  task automatic offer_query(input query_t q, input push_res_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      repeat ($urandom_range(0, 8)) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, q.r, q.py, q.px};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_pushes.push_back(want);
  endtask

  // stop offering and let every owed result come out before touching registers
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pushes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver: stretches of steady, patchy and sparse ready, and now and then
  // a long hold-off so the queue fills and the input side backs up
  initial begin : result_sink
    int seg;
    int mode;
    m_axis_tready <= 1'b0;
    seg = 0;
    forever begin
      mode = $urandom_range(0, 3);
      if (seg % 12 == 5) begin
        repeat (120) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(8, 40)) begin
          @(negedge clk_i);
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
      seg++;
    end
  end

  // compare each result item with the oldest owed one
  always @(posedge clk_i) begin : check_results
    push_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pushes.size() == 0) begin
        $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, m_axis_tuser[0],
                 $signed(m_axis_tdata[23:0]), $signed(m_axis_tdata[47:24]));
        mismatch_count++;
      end else begin
        want = pending_pushes.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_axis_tuser[0]);
          mismatch_count++;
        end
        if (m_axis_tdata[23:0] !== want.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, want.x,
                   $signed(m_axis_tdata[23:0]));
          mismatch_count++;
        end
        if (m_axis_tdata[47:24] !== want.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, want.y,
                   $signed(m_axis_tdata[47:24]));
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    query_t    q;
    push_res_t want;
    longint    span, cx, cy;
    int        sel;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    burst_left     = 0;
    box_cfg = '{center_x: RST_CENTER_X, center_y: RST_CENTER_Y,
                cos_angle: RST_COS_ANGLE, sin_angle: RST_SIN_ANGLE,
                box_width: RST_BOX_WIDTH, box_height: RST_BOX_HEIGHT,
                push_margin: RST_PUSH_MARGIN};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows on the reset box
    foreach (DIR_ROWS[i]) begin
      q = '{px: DIR_ROWS[i].px, py: DIR_ROWS[i].py, r: DIR_ROWS[i].r};
      if (DIR_ROWS[i].typed) begin
        want = '{hit: DIR_ROWS[i].hit, x: DIR_ROWS[i].ex, y: DIR_ROWS[i].ey};
      end else begin
        want = predict_push(q);
      end
      offer_query(q, want);
    end
    drain_results();

    // random phases, each on a fresh box
    for (int phase = 0; phase < 12; phase++) begin
      load_box(phase);
      cx = box_cfg.center_x;
      cy = box_cfg.center_y;
      for (int n = 0; n < 112; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
          // anywhere in the coordinate space, any radius
          q.px = COORD_W'($urandom);
          q.py = COORD_W'($urandom);
          q.r  = RADIUS_W'($urandom);
        end else begin
          // close to the box so hits and pushes are common
          q.r  = RADIUS_W'((sel == 2) ? $urandom : $urandom_range(0, 4096));
          span = ((box_cfg.box_width > box_cfg.box_height) ? box_cfg.box_width
                                                           : box_cfg.box_height) / 2
                 + q.r + box_cfg.push_margin + 512;
          if (span > COORD_TOP) span = COORD_TOP;
          q.px = clamp_coord(cx + longint'($urandom_range(0, 32'(2 * span))) - span);
          q.py = clamp_coord(cy + longint'($urandom_range(0, 32'(2 * span))) - span);
        end
        offer_query(q, predict_push(q));
      end
      drain_results();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pushes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
